### rtl/core/tlsp_pkg.sv
package tlsp_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int WEIGHT_BITS   = 8;
    localparam int MAX_THICKNESS = 1000;

    localparam int THICK_BITS    = 10;
    localparam int HALF_BITS     = THICK_BITS - 1;
    localparam int MAJ_BITS      = COORD_BITS + 1;
    localparam int POS_BITS      = COORD_BITS + 1;
    localparam int IP_BITS       = COORD_BITS + 2;
    localparam int ICPT_BITS     = IP_BITS + FRAC_BITS;
    localparam int SLOPE_BITS    = FRAC_BITS + 2;
    localparam int DIV_STEPS     = FRAC_BITS + 2;
    localparam int QUOT_BITS     = DIV_STEPS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV
    } t_back_state;

    typedef struct packed {
        t_cmd                          cmd;
        logic                          steep;
        logic signed [COORD_BITS-1:0]  a_maj;
        logic signed [COORD_BITS-1:0]  a_min;
        logic signed [COORD_BITS-1:0]  b_maj;
        logic signed [COORD_BITS-1:0]  b_min;
    } t_cmd_entry;

    typedef struct packed {
        logic       valid;
        t_cmd_entry entry;
    } t_q_port;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } t_div_rsp;

    // fraction scaled to weight bits, truncated
    function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS+WEIGHT_BITS-1:0] scaled;
        scaled = {frac, {WEIGHT_BITS{1'b0}}};
        return scaled[FRAC_BITS+WEIGHT_BITS-1:FRAC_BITS];
    endfunction

endpackage

### rtl/core/tlsp_if.sv
interface tlsp_in_if;
    import tlsp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlsp_out_if;
    import tlsp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         steep_line;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [POS_BITS-1:0]   interior_first;
    logic [THICK_BITS-1:0]        interior_count;
    logic signed [POS_BITS-1:0]   lower_edge_pos;
    logic [WEIGHT_BITS-1:0]       lower_edge_weight;
    logic signed [POS_BITS-1:0]   upper_edge_pos;
    logic [WEIGHT_BITS-1:0]       upper_edge_weight;
    logic                         last_span;

    modport source (output valid, steep_line, major_pos, interior_first, interior_count,
                    lower_edge_pos, lower_edge_weight, upper_edge_pos, upper_edge_weight,
                    last_span, input ready);
    modport sink   (input valid, steep_line, major_pos, interior_first, interior_count,
                    lower_edge_pos, lower_edge_weight, upper_edge_pos, upper_edge_weight,
                    last_span, output ready);
endinterface

### rtl/core/thick_antialiased_line_spans_core.sv
// channel   direction  contents
// i_in      in         cmd, start_x, start_y, end_x, end_y
// o_out     out        at most one column span per step word
// i_cfg_*   in         line_thickness write, no read-back
//
// a step word yields at most one span and waits in the queue while the output register
// holds a span not yet taken; a begin word holds the back end in ST_SETUP and ST_DIV,
// the latter for the one-bit-a-cycle slope divider; a begin with zero dx skips ST_DIV
// a two-word queue sits between the front and back ends; a full queue drops i_in.ready
// a span waits in the output register while the back end takes the next word
// reset is synchronous, active low; thickness resets to 15, no line loaded
module thick_antialiased_line_spans_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlsp_pkg::THICK_BITS-1:0] i_cfg_data,
    tlsp_in_if.sink                         i_in,
    tlsp_out_if.source                      o_out
);
    import tlsp_pkg::*;

    t_q_port  q_wr;
    t_q_port  q_rd;
    logic     q_full;
    logic     q_pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    tlsp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    tlsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    tlsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tlsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rd       (q_rd),
        .o_pop      (q_pop),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .o_out      (o_out)
    );

endmodule

### rtl/core/tlsp_front.sv
module tlsp_front (
    tlsp_in_if.sink          i_in,
    input  logic             i_q_full,
    output tlsp_pkg::t_q_port o_q_wr
);
    import tlsp_pkg::*;

    logic signed [COORD_BITS:0] dx_s;
    logic signed [COORD_BITS:0] dy_s;
    logic [COORD_BITS:0]        adx;
    logic [COORD_BITS:0]        ady;
    logic                       steep;

    assign dx_s  = {i_in.end_x[COORD_BITS-1], i_in.end_x}
                 - {i_in.start_x[COORD_BITS-1], i_in.start_x};
    assign dy_s  = {i_in.end_y[COORD_BITS-1], i_in.end_y}
                 - {i_in.start_y[COORD_BITS-1], i_in.start_y};
    assign adx   = dx_s[COORD_BITS] ? -dx_s : dx_s;
    assign ady   = dy_s[COORD_BITS] ? -dy_s : dy_s;
    assign steep = ady > adx;

    assign i_in.ready = !i_q_full;

    always_comb begin
        o_q_wr.valid       = i_in.valid && !i_q_full;
        o_q_wr.entry.cmd   = t_cmd'(i_in.cmd);
        o_q_wr.entry.steep = steep;
        if (steep) begin
            o_q_wr.entry.a_maj = i_in.start_y;
            o_q_wr.entry.a_min = i_in.start_x;
            o_q_wr.entry.b_maj = i_in.end_y;
            o_q_wr.entry.b_min = i_in.end_x;
        end else begin
            o_q_wr.entry.a_maj = i_in.start_x;
            o_q_wr.entry.a_min = i_in.start_y;
            o_q_wr.entry.b_maj = i_in.end_x;
            o_q_wr.entry.b_min = i_in.end_y;
        end
    end

endmodule

### rtl/core/tlsp_queue.sv
module tlsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlsp_pkg::t_q_port i_wr,
    input  logic              i_pop,
    output tlsp_pkg::t_q_port o_rd,
    output logic              o_full
);
    import tlsp_pkg::*;

    t_cmd_entry           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_pop;

    assign o_full     = r_count == QCNT_BITS'(QUEUE_DEPTH);
    assign o_rd.valid = r_count != '0;
    assign o_rd.entry = r_mem[r_rptr];
    assign do_pop     = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wptr <= (r_wptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_wr.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr.valid && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wptr] <= i_wr.entry;
        end
    end

endmodule

### rtl/core/tlsp_div.sv
module tlsp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlsp_pkg::t_div_req i_req,
    output tlsp_pkg::t_div_rsp o_rsp
);
    import tlsp_pkg::*;

    // quotient of num * 2^(FRAC_BITS+1) / den, one bit a cycle
    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [COORD_BITS-1:0]   r_rem;
    logic [COORD_BITS-1:0]   r_den;
    logic [DIV_STEPS-1:0]    r_bits;
    logic [QUOT_BITS-1:0]    r_quot;
    logic [COORD_BITS:0]     shifted;
    logic                    fits;

    assign shifted = {r_rem, r_bits[DIV_STEPS-1]};
    assign fits    = shifted >= {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_BITS'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num[COORD_BITS-1:1]};
            r_bits <= {i_req.num[0], {(DIV_STEPS-1){1'b0}}};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? COORD_BITS'(shifted - {1'b0, r_den}) : shifted[COORD_BITS-1:0];
            r_bits <= {r_bits[DIV_STEPS-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_BITS-2:0], fits};
        end
    end

endmodule

### rtl/core/tlsp_back.sv
module tlsp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [tlsp_pkg::THICK_BITS-1:0] i_cfg_data,
    input  tlsp_pkg::t_q_port      i_rd,
    output logic                   o_pop,
    output tlsp_pkg::t_div_req     o_div_req,
    input  tlsp_pkg::t_div_rsp     i_div_rsp,
    tlsp_out_if.source             o_out
);
    import tlsp_pkg::*;

    t_back_state                  r_state, n_state;
    logic [THICK_BITS-1:0]        r_thick, n_thick;
    logic                         r_steep, n_steep;
    logic                         r_active, n_active;
    logic signed [MAJ_BITS-1:0]   r_cur, n_cur;
    logic signed [MAJ_BITS-1:0]   r_end, n_end;
    logic signed [ICPT_BITS-1:0]  r_icpt, n_icpt;
    logic signed [SLOPE_BITS-1:0] r_slope, n_slope;
    logic signed [COORD_BITS-1:0] r_a_maj, n_a_maj;
    logic signed [COORD_BITS-1:0] r_a_min, n_a_min;
    logic signed [COORD_BITS-1:0] r_b_maj, n_b_maj;
    logic signed [COORD_BITS-1:0] r_b_min, n_b_min;
    logic                         r_dy_neg, n_dy_neg;

    logic                         r_out_valid, n_out_valid;
    logic                         r_o_steep, n_o_steep;
    logic signed [COORD_BITS-1:0] r_o_major, n_o_major;
    logic signed [POS_BITS-1:0]   r_o_lo, n_o_lo;
    logic [THICK_BITS-1:0]        r_o_count, n_o_count;
    logic [WEIGHT_BITS-1:0]       r_o_lo_w, n_o_lo_w;
    logic signed [POS_BITS-1:0]   r_o_hi, n_o_hi;
    logic [WEIGHT_BITS-1:0]       r_o_hi_w, n_o_hi_w;
    logic                         r_o_last, n_o_last;

    logic                         out_free;
    logic                         swap;
    logic signed [COORD_BITS:0]   dx_s;
    logic signed [COORD_BITS:0]   dy_s;
    logic [COORD_BITS-1:0]        ady;
    logic [THICK_BITS-1:0]        thick_sat;
    logic [HALF_BITS-1:0]         half;
    logic signed [IP_BITS-1:0]    ip;
    logic signed [IP_BITS-1:0]    half_s;
    logic signed [IP_BITS-1:0]    ip_lo;
    logic signed [IP_BITS-1:0]    ip_hi;
    logic [WEIGHT_BITS-1:0]       w;
    logic signed [MAJ_BITS-1:0]   cur_next;
    logic                         last;
    logic [QUOT_BITS:0]           quot_rnd;
    logic [SLOPE_BITS-1:0]        mag;
    logic signed [SLOPE_BITS-1:0] div_slope;
    logic signed [SLOPE_BITS-1:0] fin_slope;
    logic signed [ICPT_BITS-1:0]  fin_icpt;
    logic signed [MAJ_BITS-1:0]   fin_cur;
    logic signed [MAJ_BITS-1:0]   fin_end;

    assign out_free = !r_out_valid || o_out.ready;
    assign swap     = i_rd.entry.a_maj > i_rd.entry.b_maj;

    assign dx_s = {r_b_maj[COORD_BITS-1], r_b_maj} - {r_a_maj[COORD_BITS-1], r_a_maj};
    assign dy_s = {r_b_min[COORD_BITS-1], r_b_min} - {r_a_min[COORD_BITS-1], r_a_min};
    assign ady  = COORD_BITS'(dy_s[COORD_BITS] ? -dy_s : dy_s);

    assign thick_sat = (int'(r_thick) > MAX_THICKNESS) ? THICK_BITS'(MAX_THICKNESS) : r_thick;
    assign half      = thick_sat[THICK_BITS-1:1];
    assign half_s    = $signed({{(IP_BITS-HALF_BITS){1'b0}}, half});
    assign ip        = r_icpt[ICPT_BITS-1:FRAC_BITS];
    assign ip_lo     = ip - half_s;
    assign ip_hi     = ip + half_s;
    assign w         = weight_of(r_icpt[FRAC_BITS-1:0]);
    assign cur_next  = r_cur + MAJ_BITS'(1);
    assign last      = cur_next >= r_end;

    // round half up on the doubled quotient
    assign quot_rnd  = {1'b0, i_div_rsp.quot} + (QUOT_BITS+1)'(1);
    assign mag       = quot_rnd[QUOT_BITS:1];
    assign div_slope = r_dy_neg ? -$signed(mag) : $signed(mag);
    assign fin_slope = (r_state == ST_SETUP) ? SLOPE_BITS'(1 << FRAC_BITS) : div_slope;
    assign fin_icpt  = $signed({{(IP_BITS-COORD_BITS){r_a_min[COORD_BITS-1]}}, r_a_min,
                                {FRAC_BITS{1'b0}}})
                     + $signed({{(ICPT_BITS-SLOPE_BITS){fin_slope[SLOPE_BITS-1]}}, fin_slope});
    assign fin_cur   = {r_a_maj[COORD_BITS-1], r_a_maj} + MAJ_BITS'(1);
    assign fin_end   = {r_b_maj[COORD_BITS-1], r_b_maj};

    always_comb begin
        n_state     = r_state;
        n_thick     = i_cfg_we ? i_cfg_data : r_thick;
        n_steep     = r_steep;
        n_active    = r_active;
        n_cur       = r_cur;
        n_end       = r_end;
        n_icpt      = r_icpt;
        n_slope     = r_slope;
        n_a_maj     = r_a_maj;
        n_a_min     = r_a_min;
        n_b_maj     = r_b_maj;
        n_b_min     = r_b_min;
        n_dy_neg    = r_dy_neg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_steep   = r_o_steep;
        n_o_major   = r_o_major;
        n_o_lo      = r_o_lo;
        n_o_count   = r_o_count;
        n_o_lo_w    = r_o_lo_w;
        n_o_hi      = r_o_hi;
        n_o_hi_w    = r_o_hi_w;
        n_o_last    = r_o_last;
        o_pop       = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = ady;
        o_div_req.den   = dx_s[COORD_BITS-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_rd.valid) begin
                    if (i_rd.entry.cmd == CMD_BEGIN) begin
                        o_pop    = 1'b1;
                        n_steep  = i_rd.entry.steep;
                        n_active = 1'b0;
                        n_a_maj  = swap ? i_rd.entry.b_maj : i_rd.entry.a_maj;
                        n_a_min  = swap ? i_rd.entry.b_min : i_rd.entry.a_min;
                        n_b_maj  = swap ? i_rd.entry.a_maj : i_rd.entry.b_maj;
                        n_b_min  = swap ? i_rd.entry.a_min : i_rd.entry.b_min;
                        n_state  = ST_SETUP;
                    end else if (!r_active) begin
                        o_pop = 1'b1;
                    end else if (r_cur >= r_end) begin
                        o_pop    = 1'b1;
                        n_active = 1'b0;
                    end else if (out_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_o_steep   = r_steep;
                        n_o_major   = r_cur[COORD_BITS-1:0];
                        n_o_lo      = ip_lo[POS_BITS-1:0];
                        n_o_count   = {half, 1'b0};
                        n_o_lo_w    = ~w;
                        n_o_hi      = ip_hi[POS_BITS-1:0];
                        n_o_hi_w    = w;
                        n_o_last    = last;
                        n_icpt      = r_icpt + $signed({{(ICPT_BITS-SLOPE_BITS)
                                                        {r_slope[SLOPE_BITS-1]}}, r_slope});
                        n_cur       = cur_next;
                        if (last) begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            ST_SETUP: begin
                n_dy_neg = dy_s[COORD_BITS];
                if (dx_s == '0) begin
                    n_slope  = fin_slope;
                    n_icpt   = fin_icpt;
                    n_cur    = fin_cur;
                    n_end    = fin_end;
                    n_active = fin_cur < fin_end;
                    n_state  = ST_IDLE;
                end else begin
                    o_div_req.start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_div_rsp.done) begin
                    n_slope  = fin_slope;
                    n_icpt   = fin_icpt;
                    n_cur    = fin_cur;
                    n_end    = fin_end;
                    n_active = fin_cur < fin_end;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thick     <= THICK_BITS'(15);
            r_steep     <= 1'b0;
            r_active    <= 1'b0;
            r_cur       <= '0;
            r_end       <= '0;
            r_icpt      <= '0;
            r_slope     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_thick     <= n_thick;
            r_steep     <= n_steep;
            r_active    <= n_active;
            r_cur       <= n_cur;
            r_end       <= n_end;
            r_icpt      <= n_icpt;
            r_slope     <= n_slope;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_maj   <= n_a_maj;
        r_a_min   <= n_a_min;
        r_b_maj   <= n_b_maj;
        r_b_min   <= n_b_min;
        r_dy_neg  <= n_dy_neg;
        r_o_steep <= n_o_steep;
        r_o_major <= n_o_major;
        r_o_lo    <= n_o_lo;
        r_o_count <= n_o_count;
        r_o_lo_w  <= n_o_lo_w;
        r_o_hi    <= n_o_hi;
        r_o_hi_w  <= n_o_hi_w;
        r_o_last  <= n_o_last;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.steep_line        = r_o_steep;
    assign o_out.major_pos         = r_o_major;
    assign o_out.interior_first    = r_o_lo;
    assign o_out.interior_count    = r_o_count;
    assign o_out.lower_edge_pos    = r_o_lo;
    assign o_out.lower_edge_weight = r_o_lo_w;
    assign o_out.upper_edge_pos    = r_o_hi;
    assign o_out.upper_edge_weight = r_o_hi_w;
    assign o_out.last_span         = r_o_last;

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlsp_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 520;
    localparam int ROUNDS        = 6;
    localparam int SHOW_LIMIT    = 10;

    typedef struct packed {
        t_cmd                         cmd;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
    } t_line_word;

    typedef struct packed {
        logic                         steep;
        logic signed [COORD_BITS-1:0] major;
        logic signed [POS_BITS-1:0]   first;
        logic [THICK_BITS-1:0]        count;
        logic signed [POS_BITS-1:0]   lo_pos;
        logic [WEIGHT_BITS-1:0]       lo_w;
        logic signed [POS_BITS-1:0]   hi_pos;
        logic [WEIGHT_BITS-1:0]       hi_w;
        logic                         last;
    } t_span;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [THICK_BITS-1:0] thick;
        t_line_word            word;
        logic                  typed;
        t_span                 span;
    } t_dir_row;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_BEAT,
        RX_SPARSE
    } t_rx_mode;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [THICK_BITS-1:0] cfg_data = '0;
    logic                  tx_valid = 1'b0;
    t_line_word            tx_word  = '0;
    logic                  rx_ready = 1'b0;

    tlsp_in_if  in_if ();
    tlsp_out_if out_if ();

    assign in_if.valid   = tx_valid;
    assign in_if.cmd     = tx_word.cmd;
    assign in_if.start_x = tx_word.sx;
    assign in_if.start_y = tx_word.sy;
    assign in_if.end_x   = tx_word.ex;
    assign in_if.end_y   = tx_word.ey;
    assign out_if.ready  = rx_ready;

    thick_antialiased_line_spans_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always #1 i_clk = ~i_clk;

    // line state of the span generator
    logic [THICK_BITS-1:0]        thick_q     = 10'd15;
    logic                         steep_q     = 1'b0;
    logic signed [MAJ_BITS-1:0]   major_q     = '0;
    logic signed [MAJ_BITS-1:0]   major_end_q = '0;
    logic signed [ICPT_BITS-1:0]  icpt_q      = '0;
    logic signed [SLOPE_BITS-1:0] slope_q     = '0;
    logic                         active_q    = 1'b0;

    t_span span_q[$];
    int    burst_left  = 0;
    int    err_count   = 0;
    int    shown       = 0;
    int    cycle_count = 0;

    function automatic logic next_span(input t_line_word w, output t_span s);
        longint ax, ay, bx, by, t, dx, dy, q, ip, half;
        logic   st, last;
        s = '0;
        if (w.cmd == CMD_BEGIN) begin
            ax = $signed(w.sx);
            ay = $signed(w.sy);
            bx = $signed(w.ex);
            by = $signed(w.ey);
            st = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
            if (st) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            if (dx == 0) begin
                q = longint'(1) << FRAC_BITS;
            end else begin
                q = ((((dy < 0) ? -dy : dy) << (FRAC_BITS + 1)) + dx) / (2 * dx);
                if (dy < 0) q = -q;
            end
            steep_q     = st;
            slope_q     = SLOPE_BITS'(q);
            icpt_q      = ICPT_BITS'(ay * (longint'(1) << FRAC_BITS) + q);
            major_q     = MAJ_BITS'(ax + 1);
            major_end_q = MAJ_BITS'(bx);
            active_q    = (ax + 1) < bx;
            return 1'b0;
        end
        if (!active_q) return 1'b0;
        if (major_q >= major_end_q) begin
            active_q = 1'b0;
            return 1'b0;
        end
        half = ((thick_q > MAX_THICKNESS) ? MAX_THICKNESS : int'(thick_q)) / 2;
        ip   = longint'(icpt_q) >>> FRAC_BITS;
        last = (longint'(major_q) + 1) >= longint'(major_end_q);
        s.steep  = steep_q;
        s.major  = major_q[COORD_BITS-1:0];
        s.first  = POS_BITS'(ip - half);
        s.count  = THICK_BITS'(half * 2);
        s.lo_pos = POS_BITS'(ip - half);
        s.hi_w   = icpt_q[FRAC_BITS-1 -: WEIGHT_BITS];
        s.lo_w   = ~s.hi_w;
        s.hi_pos = POS_BITS'(ip + half);
        s.last   = last;
        icpt_q   = icpt_q + ICPT_BITS'(slope_q);
        major_q  = major_q + MAJ_BITS'(1);
        if (last) active_q = 1'b0;
        return 1'b1;
    endfunction

    function automatic string span_text(t_span s);
        return $sformatf("st=%0b maj=%0d first=%0d cnt=%0d lo=%0d/%0d hi=%0d/%0d last=%0b",
                         s.steep, s.major, s.first, s.count, s.lo_pos, s.lo_w,
                         s.hi_pos, s.hi_w, s.last);
    endfunction

    function automatic t_dir_row row_cfg(int v);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.thick = THICK_BITS'(v);
        return r;
    endfunction

    function automatic t_dir_row row_word(t_cmd c, int sx, int sy, int ex, int ey);
        t_dir_row r;
        r          = '0;
        r.kind     = ROW_WORD;
        r.word.cmd = c;
        r.word.sx  = COORD_BITS'(sx);
        r.word.sy  = COORD_BITS'(sy);
        r.word.ex  = COORD_BITS'(ex);
        r.word.ey  = COORD_BITS'(ey);
        return r;
    endfunction

    function automatic t_dir_row row_span(int st, int major, int first, int count, int lo_pos,
                                          int lo_w, int hi_pos, int hi_w, int last);
        t_dir_row r;
        r             = row_word(CMD_STEP, 0, 0, 0, 0);
        r.typed       = 1'b1;
        r.span.steep  = st[0];
        r.span.major  = COORD_BITS'(major);
        r.span.first  = POS_BITS'(first);
        r.span.count  = THICK_BITS'(count);
        r.span.lo_pos = POS_BITS'(lo_pos);
        r.span.lo_w   = WEIGHT_BITS'(lo_w);
        r.span.hi_pos = POS_BITS'(hi_pos);
        r.span.hi_w   = WEIGHT_BITS'(hi_w);
        r.span.last   = last[0];
        return r;
    endfunction

    function automatic t_line_word rand_step();
        t_line_word w;
        w.cmd = CMD_STEP;
        w.sx  = COORD_BITS'($urandom);
        w.sy  = COORD_BITS'($urandom);
        w.ex  = COORD_BITS'($urandom);
        w.ey  = COORD_BITS'($urandom);
        return w;
    endfunction

    function automatic longint pick_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom);
        case ($urandom_range(0, 11))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2: v = 16'sh8001;
            3: v = 16'sh7ffe;
            default: ;
        endcase
        return v;
    endfunction

    function automatic longint far_end(longint a, int d);
        if (a + d > 32767) return a - d;
        if (a - d < -32768) return a + d;
        return ($urandom_range(0, 1) != 0) ? a + d : a - d;
    endfunction

    task automatic send_word(input t_line_word w, input logic typed, input t_span typed_span,
                             output logic got);
        int    gap;
        t_span s;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 4) gap = 0;
            else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
            if (gap > 0) begin
                tx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        tx_valid <= 1'b1;
        tx_word  <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        got = next_span(w, s);
        if (typed) span_q.push_back(typed_span);
        else if (got) span_q.push_back(s);
    endtask

    task automatic settle();
        tx_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_thickness(input logic [THICK_BITS-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        thick_q  = v;
    endtask

    // begin word followed by the steps that walk the line, sometimes cut short or overrun
    task automatic run_line(inout int counted);
        int         len, dmin, steps;
        longint     a_maj, a_min, b_maj, b_min;
        t_line_word w;
        logic       got;
        len   = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        dmin  = $urandom_range(0, len);
        a_maj = pick_coord();
        a_min = pick_coord();
        b_maj = far_end(a_maj, len);
        b_min = far_end(a_min, dmin);
        w.cmd = CMD_BEGIN;
        if ($urandom_range(0, 1) != 0) begin
            w.sx = COORD_BITS'(a_min);
            w.sy = COORD_BITS'(a_maj);
            w.ex = COORD_BITS'(b_min);
            w.ey = COORD_BITS'(b_maj);
        end else begin
            w.sx = COORD_BITS'(a_maj);
            w.sy = COORD_BITS'(a_min);
            w.ex = COORD_BITS'(b_maj);
            w.ey = COORD_BITS'(b_min);
        end
        send_word(w, 1'b0, '0, got);
        counted++;
        steps = (len > 1) ? len - 1 : 0;
        case ($urandom_range(0, 9))
            0, 1: steps += $urandom_range(1, 3);
            2: steps = $urandom_range(0, steps);
            default: ;
        endcase
        repeat (steps) begin
            send_word(rand_step(), 1'b0, '0, got);
            counted++;
        end
    endtask

    always @(posedge i_clk) begin
        t_span seen, want;
        if (i_rst_n && out_if.valid && rx_ready) begin
            seen.steep  = out_if.steep_line;
            seen.major  = out_if.major_pos;
            seen.first  = out_if.interior_first;
            seen.count  = out_if.interior_count;
            seen.lo_pos = out_if.lower_edge_pos;
            seen.lo_w   = out_if.lower_edge_weight;
            seen.hi_pos = out_if.upper_edge_pos;
            seen.hi_w   = out_if.upper_edge_weight;
            seen.last   = out_if.last_span;
            if (span_q.size() == 0) begin
                err_count++;
                if (shown < SHOW_LIMIT) begin
                    shown++;
                    $display("unexpected span: %s", span_text(seen));
                end
            end else begin
                want = span_q.pop_front();
                if (seen !== want) begin
                    err_count++;
                    if (shown < SHOW_LIMIT) begin
                        shown++;
                        $display("span mismatch\n  expected %s\n  actual   %s",
                                 span_text(want), span_text(seen));
                    end
                end
            end
        end
    end

    // receiver backpressure
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FREE: rx_ready <= 1'b1;
            RX_COIN: rx_ready <= ($urandom_range(0, 1) != 0);
            RX_BEAT: rx_ready <= ((rx_tick % 4) != 3);
            default: rx_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_dir_row   rows[$];
        logic       got;
        int         counted;
        int         pick;
        logic [THICK_BITS-1:0] thick;
        t_line_word w;

        // step with no line, then a line too short for any interior column
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        rows.push_back(row_word(CMD_BEGIN, 0, 0, 1, 0));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        // flat line, default thickness
        rows.push_back(row_word(CMD_BEGIN, 0, 0, 4, 0));
        rows.push_back(row_span(0, 1, -7, 14, -7, 255, 7, 0, 0));
        rows.push_back(row_span(0, 2, -7, 14, -7, 255, 7, 0, 0));
        rows.push_back(row_span(0, 3, -7, 14, -7, 255, 7, 0, 1));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        // zero dx
        rows.push_back(row_word(CMD_BEGIN, 5, 5, 5, 5));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        // steep line
        rows.push_back(row_word(CMD_BEGIN, 0, 0, 0, 3));
        rows.push_back(row_span(1, 1, -7, 14, -7, 255, 7, 0, 0));
        rows.push_back(row_span(1, 2, -7, 14, -7, 255, 7, 0, 1));
        // reversed diagonal, then begins that drop active lines at the coordinate extremes
        rows.push_back(row_word(CMD_BEGIN, 10, 0, 0, 10));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        rows.push_back(row_word(CMD_BEGIN, -32768, -32768, 32767, 32767));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        rows.push_back(row_word(CMD_BEGIN, 32767, -32768, -32768, 32767));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        rows.push_back(row_word(CMD_BEGIN, -32768, 32767, -32767, -32768));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        // fractional intercept
        rows.push_back(row_word(CMD_BEGIN, 0, 0, 3, 1));
        rows.push_back(row_word(CMD_STEP, 0, 0, 0, 0));
        // zero thickness
        rows.push_back(row_cfg(0));
        rows.push_back(row_word(CMD_BEGIN, 0, 0, 3, 0));
        rows.push_back(row_span(0, 1, 0, 0, 0, 255, 0, 0, 0));
        rows.push_back(row_span(0, 2, 0, 0, 0, 255, 0, 0, 1));
        // thickness above the maximum saturates
        rows.push_back(row_cfg(1023));
        rows.push_back(row_word(CMD_BEGIN, 0, -5, 3, -5));
        rows.push_back(row_span(0, 1, -505, 1000, -505, 255, 495, 0, 0));
        rows.push_back(row_span(0, 2, -505, 1000, -505, 255, 495, 0, 1));
        rows.push_back(row_cfg(1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_thickness(rows[i].thick);
            else send_word(rows[i].word, rows[i].typed, rows[i].span, got);
        end

        for (int r = 0; r < ROUNDS; r++) begin
            case (r)
                0: thick = THICK_BITS'($urandom_range(2, 999));
                1: thick = 10'd1;
                2: thick = THICK_BITS'(MAX_THICKNESS);
                3: thick = 10'd1023;
                4: thick = 10'd0;
                default: thick = THICK_BITS'($urandom_range(0, 1023));
            endcase
            write_thickness(thick);
            counted = 0;
            while (counted < RANDOM_WORDS / ROUNDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    run_line(counted);
                end else if (pick < 90) begin
                    w     = rand_step();
                    w.cmd = CMD_BEGIN;
                    send_word(w, 1'b0, '0, got);
                    counted++;
                    repeat ($urandom_range(0, 4)) begin
                        send_word(rand_step(), 1'b0, '0, got);
                        counted++;
                    end
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_word(rand_step(), 1'b0, '0, got);
                        counted++;
                    end
                end
            end
        end

        settle();
        if (err_count == 0 && span_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tlsp_pkg.sv
rtl/core/tlsp_if.sv
rtl/core/tlsp_front.sv
rtl/core/tlsp_queue.sv
rtl/core/tlsp_div.sv
rtl/core/tlsp_back.sv
rtl/core/thick_antialiased_line_spans_core.sv
tb/testbench.sv
